@@ design/pcts_pkg.sv @@
// Shared types, register indexes and arithmetic helpers of the PCM to stereo converter.
package pcts_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_IS_8BIT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HALF_RATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_MONO      = 2'd2;

   // Offset that maps an unsigned 8-bit sample shifted up by eight onto the signed range.
   localparam logic [SAMPLE_W-1:0] U8_OFFSET = 16'd32767;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // One queued item: everything the back end needs to emit its frames.
   typedef struct packed {
      sample_type held_left;
      sample_type held_right;
      sample_type new_left;
      sample_type new_right;
      logic       has_held;
      logic       last;
      logic       half_rate;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      KIND_HELD     = 2'd0,
      KIND_MID_HELD = 2'd1,
      KIND_NEW      = 2'd2,
      KIND_MID_ZERO = 2'd3
   } frame_kind_type;

   // (a + b + 1) / 2 truncated toward zero; the result always fits in 16 bits.
   function automatic sample_type mid_value(input sample_type a, input sample_type b);
      logic signed [SAMPLE_W+1:0] sum;
      logic signed [SAMPLE_W+1:0] adj;
      sum = {{2{a[SAMPLE_W-1]}}, a} + {{2{b[SAMPLE_W-1]}}, b} + 18'sd1;
      adj = sum + {{(SAMPLE_W+1){1'b0}}, sum[SAMPLE_W+1]};
      mid_value = adj[SAMPLE_W:1];
   endfunction

endpackage

@@ design/pcts_front.sv @@
// Front end: configuration registers, sample conversion and held-frame tracking.
module pcts_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [pcts_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [0:0]                          csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [pcts_pkg::SAMPLE_W-1:0] req_left_sample,
   input  logic signed [pcts_pkg::SAMPLE_W-1:0] req_right_sample,
   input  logic                                req_last_frame,
   input  pcts_pkg::queue_status_type          queue_status,
   output logic                                push,
   output pcts_pkg::cmd_type                   push_cmd,
   output logic                                held_valid
);

   logic                 is_8bit_ff, is_8bit_in;
   logic                 half_rate_ff, half_rate_in;
   logic                 mono_ff, mono_in;
   logic                 held_valid_ff, held_valid_in;
   pcts_pkg::sample_type held_left_ff, held_left_in;
   pcts_pkg::sample_type held_right_ff, held_right_in;
   pcts_pkg::sample_type conv_left;
   pcts_pkg::sample_type conv_right;
   logic                 accept;
   logic                 csr_hit;

   function automatic pcts_pkg::sample_type convert(input logic u8,
                                                    input pcts_pkg::sample_type raw);
      if (u8) begin
         convert = {raw[7:0], 8'h00} - pcts_pkg::U8_OFFSET;
      end else begin
         convert = raw;
      end
   endfunction

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign conv_left  = convert(is_8bit_ff, req_left_sample);
   assign conv_right = mono_ff ? conv_left : convert(is_8bit_ff, req_right_sample);

   assign csr_hit = csr_we && (csr_index == pcts_pkg::REG_SOURCE_IS_8BIT ||
                               csr_index == pcts_pkg::REG_SOURCE_HALF_RATE ||
                               csr_index == pcts_pkg::REG_SOURCE_MONO);

   // A half-rate item that is neither last nor has a predecessor only gets held.
   assign push = accept && (!half_rate_ff || held_valid_ff || req_last_frame);

   always_comb begin
      push_cmd.held_left  = held_left_ff;
      push_cmd.held_right = held_right_ff;
      push_cmd.new_left   = conv_left;
      push_cmd.new_right  = conv_right;
      push_cmd.has_held   = held_valid_ff;
      push_cmd.last       = req_last_frame;
      push_cmd.half_rate  = half_rate_ff;
   end

   always_comb begin
      is_8bit_in    = is_8bit_ff;
      half_rate_in  = half_rate_ff;
      mono_in       = mono_ff;
      held_valid_in = held_valid_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      if (csr_we && csr_index == pcts_pkg::REG_SOURCE_IS_8BIT) begin
         is_8bit_in = csr_wdata[0];
      end
      if (csr_we && csr_index == pcts_pkg::REG_SOURCE_HALF_RATE) begin
         half_rate_in = csr_wdata[0];
      end
      if (csr_we && csr_index == pcts_pkg::REG_SOURCE_MONO) begin
         mono_in = csr_wdata[0];
      end
      if (accept && half_rate_ff) begin
         if (req_last_frame) begin
            held_valid_in = 1'b0;
         end else begin
            held_valid_in = 1'b1;
            held_left_in  = conv_left;
            held_right_in = conv_right;
         end
      end
      if (csr_hit) begin
         held_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_8bit_ff    <= 1'b0;
         half_rate_ff  <= 1'b0;
         mono_ff       <= 1'b0;
         held_valid_ff <= 1'b0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
      end else begin
         is_8bit_ff    <= is_8bit_in;
         half_rate_ff  <= half_rate_in;
         mono_ff       <= mono_in;
         held_valid_ff <= held_valid_in;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
      end
   end

   assign held_valid = held_valid_ff;

endmodule

@@ design/pcts_queue.sv @@
// Small FIFO of commands between the front and back ends.
module pcts_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pcts_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output pcts_pkg::cmd_type          head_cmd,
   output pcts_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   pcts_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign head_cmd     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ design/pcts_back.sv @@
// Back end: expands each command into its output frames, one per cycle unless stalled.
module pcts_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pcts_pkg::cmd_type                    head_cmd,
   input  pcts_pkg::queue_status_type           queue_status,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pcts_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [pcts_pkg::SAMPLE_W-1:0] rsp_right_out,
   output logic                                 rsp_last_out
);

   logic [1:0]               step_ff, step_in;
   logic                     valid_ff, valid_in;
   pcts_pkg::sample_type     left_ff, left_in;
   pcts_pkg::sample_type     right_ff, right_in;
   logic                     last_ff, last_in;
   logic [2:0]               frame_count;
   logic                     final_step;
   logic                     advance;
   pcts_pkg::frame_kind_type kind;
   pcts_pkg::sample_type     mid_a_left, mid_b_left, mid_a_right, mid_b_right;
   pcts_pkg::sample_type     mid_left, mid_right;

   always_comb begin
      if (!head_cmd.half_rate) begin
         frame_count = 3'd1;
      end else begin
         frame_count = (head_cmd.has_held ? 3'd2 : 3'd0) + (head_cmd.last ? 3'd2 : 3'd0);
      end
   end

   always_comb begin
      if (!head_cmd.half_rate) begin
         kind = pcts_pkg::KIND_NEW;
      end else if (head_cmd.has_held) begin
         case (step_ff)
            2'd0:    kind = pcts_pkg::KIND_HELD;
            2'd1:    kind = pcts_pkg::KIND_MID_HELD;
            2'd2:    kind = pcts_pkg::KIND_NEW;
            default: kind = pcts_pkg::KIND_MID_ZERO;
         endcase
      end else begin
         kind = step_ff[0] ? pcts_pkg::KIND_MID_ZERO : pcts_pkg::KIND_NEW;
      end
   end

   // One shared midpoint unit per channel: against the held frame or against zero.
   always_comb begin
      if (kind == pcts_pkg::KIND_MID_HELD) begin
         mid_a_left  = head_cmd.held_left;
         mid_a_right = head_cmd.held_right;
         mid_b_left  = head_cmd.new_left;
         mid_b_right = head_cmd.new_right;
      end else begin
         mid_a_left  = head_cmd.new_left;
         mid_a_right = head_cmd.new_right;
         mid_b_left  = '0;
         mid_b_right = '0;
      end
   end

   assign mid_left  = pcts_pkg::mid_value(mid_a_left, mid_b_left);
   assign mid_right = pcts_pkg::mid_value(mid_a_right, mid_b_right);

   assign advance    = !queue_status.empty && (!valid_ff || rsp_ready);
   assign final_step = ({1'b0, step_ff} + 3'd1) == frame_count;
   assign pop        = advance && final_step;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      left_in  = left_ff;
      right_in = right_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in = 1'b1;
         step_in  = final_step ? 2'd0 : step_ff + 2'd1;
         case (kind)
            pcts_pkg::KIND_HELD: begin
               left_in  = head_cmd.held_left;
               right_in = head_cmd.held_right;
               last_in  = 1'b0;
            end
            pcts_pkg::KIND_MID_HELD: begin
               left_in  = mid_left;
               right_in = mid_right;
               last_in  = 1'b0;
            end
            pcts_pkg::KIND_NEW: begin
               left_in  = head_cmd.new_left;
               right_in = head_cmd.new_right;
               last_in  = head_cmd.last && !head_cmd.half_rate;
            end
            default: begin
               left_in  = mid_left;
               right_in = mid_right;
               last_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      last_ff  <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_left_out  = left_ff;
   assign rsp_right_out = right_ff;
   assign rsp_last_out  = last_ff;

endmodule

@@ design/pcm_to_stereo16_converter_core.sv @@
// Top level of the PCM to stereo 16-bit converter: front end, command queue and back end.
// Each source frame is converted (unsigned 8-bit or signed 16-bit, mono or stereo) by the
// front end, which also holds one frame back in half-rate mode, and queued as at most one
// command. The back end emits one output frame per cycle while rsp_ready allows, via a
// single output register; an item has one output frame at full rate, zero to four at half
// rate (two for each of the held frame and a last frame). The queue of QUEUE_DEPTH commands
// lets items keep coming in while earlier frames wait on rsp_ready. Writing any
// configuration register drops a held frame.
module pcm_to_stereo16_converter_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [pcts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [0:0]                           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [pcts_pkg::SAMPLE_W-1:0] req_left_sample,
   input  logic signed [pcts_pkg::SAMPLE_W-1:0] req_right_sample,
   input  logic                                 req_last_frame,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [pcts_pkg::SAMPLE_W-1:0] rsp_left_out,
   output logic signed [pcts_pkg::SAMPLE_W-1:0] rsp_right_out,
   output logic                                 rsp_last_out
);

   logic                       push;
   logic                       pop;
   logic                       held_valid;
   pcts_pkg::cmd_type          push_cmd;
   pcts_pkg::cmd_type          head_cmd;
   pcts_pkg::queue_status_type queue_status;

   pcts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_last_frame   (req_last_frame),
      .queue_status     (queue_status),
      .push             (push),
      .push_cmd         (push_cmd),
      .held_valid       (held_valid)
   );

   pcts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (queue_status)
   );

   pcts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .queue_status  (queue_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out),
      .rsp_last_out  (rsp_last_out)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_status.full)
      else $error("command pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("command popped from an empty queue");

   a_csr_drops_held: assert property (@(posedge clock) disable iff (reset)
      (csr_we && (csr_index == pcts_pkg::REG_SOURCE_IS_8BIT ||
                  csr_index == pcts_pkg::REG_SOURCE_HALF_RATE ||
                  csr_index == pcts_pkg::REG_SOURCE_MONO)) |=> !held_valid)
      else $error("held frame survived a configuration write");

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
